### rtl/calendar_clock_counter_defines.svh
// Assertion macros for the calendar clock counter.
// Included by the top level; no other dependencies.
`ifndef CALENDAR_CLOCK_COUNTER_DEFINES_SVH
`define CALENDAR_CLOCK_COUNTER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset.
`define CCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define CCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define CCC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CCC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/ccc_pkg.sv
// Shared types, constants and the month length function of the calendar clock.
// No dependencies.
package ccc_pkg;

  localparam int unsigned MsPerSec     = 1000;
  localparam int unsigned SetMsMax     = 990;
  localparam int unsigned SecPerMin    = 60;
  localparam int unsigned MinPerHour   = 60;
  localparam int unsigned HoursPerDay  = 24;
  localparam int unsigned MonthsPerYr  = 12;
  localparam int unsigned TickMsMax    = 999;
  localparam int unsigned TickMsReset  = 100;
  localparam int unsigned YearReset    = 2000;
  localparam int unsigned TickMsWidth  = 10;

  // Command carried in the input tuser.
  typedef enum logic {
    CmdTick = 1'b0,
    CmdSet  = 1'b1
  } cmd_e;

  // Status carried in the output tuser.
  typedef enum logic {
    StatusOk     = 1'b0,
    StatusReject = 1'b1
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    RegTickMs     = 1'b0,
    RegWinterTime = 1'b1
  } reg_e;

  // One calendar time value, used for both the held time and set requests.
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  msecond;
  } clock_time_t;

  // Days per month; codes that name no month give zero.
  localparam logic [4:0] DaysInMonth [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  // Month length with February extended in years divisible by four.
  function automatic logic [4:0] month_len(logic [3:0] month, logic [15:0] year);
    logic [4:0] len;
    len = DaysInMonth[month];
    if (month == 4'd2 && year[1:0] == 2'b00) begin
      len = 5'd29;
    end
    return len;
  endfunction

endpackage

### rtl/ccc_set_check.sv
// Validity check of a requested UTC time for the calendar clock counter.
// Depends on ccc_pkg.
module ccc_set_check (
  input  ccc_pkg::clock_time_t set_time_i,
  output logic                 set_ok_o
);
  import ccc_pkg::*;

  logic [17:0] ms_scaled;
  logic [6:0]  ms_tens;
  logic [9:0]  ms_back;
  logic        ms_ok;
  logic        date_ok;
  logic        clock_ok;

  // Milliseconds must be a multiple of ten: divide by ten via a reciprocal
  // (205 / 2048 is exact over the ten-bit range) and multiply back.
  always_comb begin
    ms_scaled = 18'(set_time_i.msecond) * 18'd205;
    ms_tens   = ms_scaled[17:11];
    ms_back   = {ms_tens, 3'b000} + {2'b00, ms_tens, 1'b0};
    ms_ok     = (set_time_i.msecond <= 10'(SetMsMax)) && (ms_back == set_time_i.msecond);
  end

  // Date fields count from one; the day must fit the month of that year.
  always_comb begin
    date_ok = (set_time_i.month >= 4'd1) && (set_time_i.month <= 4'(MonthsPerYr))
           && (set_time_i.day >= 5'd1)
           && (set_time_i.day <= month_len(set_time_i.month, set_time_i.year));
    clock_ok = (set_time_i.hour < 5'(HoursPerDay))
            && (set_time_i.minute < 6'(MinPerHour))
            && (set_time_i.second < 6'(SecPerMin));
  end

  assign set_ok_o = date_ok && clock_ok && ms_ok;

endmodule

### rtl/ccc_advance.sv
// Next-time logic of the calendar clock counter: tick carry chain, set with
// local offset, and the shared one-day date advance. Depends on ccc_pkg.
module ccc_advance (
  input  ccc_pkg::clock_time_t        time_i,
  input  ccc_pkg::cmd_e               cmd_i,
  input  ccc_pkg::clock_time_t        set_time_i,
  input  logic                        set_ok_i,
  input  logic [ccc_pkg::TickMsWidth-1:0] tick_ms_i,
  input  logic                        winter_time_i,
  output ccc_pkg::clock_time_t        time_o,
  output ccc_pkg::status_e            status_o
);
  import ccc_pkg::*;

  logic [9:0]  step;
  logic [10:0] ms_sum;
  logic        ms_carry;
  logic [5:0]  sec_inc;
  logic        sec_carry;
  logic [5:0]  min_inc;
  logic        min_carry;
  logic [4:0]  hour_inc;
  logic        hour_carry;
  clock_time_t tick_time;

  logic [4:0]  set_hour_sum;
  logic        set_roll;
  clock_time_t set_time;

  clock_time_t base_time;
  logic        roll_day;
  logic [4:0]  base_len;
  clock_time_t next_time;

  // Tick: add the clamped tick length and carry up through the hours.
  always_comb begin
    step       = (tick_ms_i > 10'(TickMsMax)) ? 10'(TickMsMax) : tick_ms_i;
    ms_sum     = {1'b0, time_i.msecond} + {1'b0, step};
    ms_carry   = ms_sum >= 11'(MsPerSec);
    sec_inc    = time_i.second + {5'd0, ms_carry};
    sec_carry  = sec_inc >= 6'(SecPerMin);
    min_inc    = time_i.minute + {5'd0, sec_carry};
    min_carry  = min_inc >= 6'(MinPerHour);
    hour_inc   = time_i.hour + {4'd0, min_carry};
    hour_carry = hour_inc >= 5'(HoursPerDay);

    tick_time         = time_i;
    tick_time.msecond = ms_carry ? 10'(ms_sum - 11'(MsPerSec)) : ms_sum[9:0];
    tick_time.second  = sec_carry ? 6'd0 : sec_inc;
    tick_time.minute  = min_carry ? 6'd0 : min_inc;
    tick_time.hour    = hour_carry ? 5'd0 : hour_inc;
  end

  // Set: store the request shifted to local time by one or two hours.
  always_comb begin
    set_hour_sum  = set_time_i.hour + (winter_time_i ? 5'd1 : 5'd2);
    set_roll      = set_hour_sum >= 5'(HoursPerDay);
    set_time      = set_time_i;
    set_time.hour = set_roll ? 5'(set_hour_sum - 5'(HoursPerDay)) : set_hour_sum;
  end

  // Pick the path, then advance the date by one day when the hour wrapped.
  always_comb begin
    if (cmd_i == CmdSet) begin
      base_time = set_time;
      roll_day  = set_roll;
    end else begin
      base_time = tick_time;
      roll_day  = hour_carry;
    end

    base_len  = month_len(base_time.month, base_time.year);
    next_time = base_time;
    if (roll_day) begin
      if (base_time.day >= base_len) begin
        next_time.day = 5'd1;
        if (base_time.month >= 4'(MonthsPerYr)) begin
          next_time.month = 4'd1;
          next_time.year  = base_time.year + 16'd1;
        end else begin
          next_time.month = base_time.month + 4'd1;
        end
      end else begin
        next_time.day = base_time.day + 5'd1;
      end
    end
  end

  // A rejected set keeps the held time unchanged.
  always_comb begin
    if (cmd_i == CmdSet && !set_ok_i) begin
      time_o   = time_i;
      status_o = StatusReject;
    end else begin
      time_o   = next_time;
      status_o = StatusOk;
    end
  end

endmodule

### rtl/calendar_clock_counter.sv
// Top level of the calendar clock counter: stream ports, configuration and
// time registers, result register. Depends on ccc_pkg, ccc_set_check,
// ccc_advance and calendar_clock_counter_defines.svh.
//
//   Channel  | Direction | Transfer when          | Carries
//   s_axis   | in        | tvalid & tready        | command (tuser), set time (tdata)
//   m_axis   | out       | tvalid & tready        | status (tuser), held time (tdata)
//   cfg      | in        | cfg_we_i               | tick_ms (index 0), winter_time (1)
//
// The held time and the result register both load at the edge where the
// input transfer happens, so one item per cycle while no result waits on m_axis_tready.
// The result shows in the cycle after the input transfer.
// The input stays ready while the result register is empty or being drained.
// Reset sets the time to 2000-01-01 00:00:00.000, tick_ms 100, winter time on.
`include "calendar_clock_counter_defines.svh"

module calendar_clock_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // set_day[4:0], set_month[8:5], set_year[24:9], set_hour[29:25],
  // set_minute[35:30], set_second[41:36], set_msecond[51:42], zero pad [55:52]
  input  logic [55:0] s_axis_tdata,
  // command[0]
  input  logic        s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // day[4:0], month[8:5], year[24:9], hour[29:25], minute[35:30],
  // second[41:36], msecond[51:42], zero pad [55:52]
  output logic [55:0] m_axis_tdata,
  // status[0]
  output logic        m_axis_tuser,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [9:0]  cfg_wdata_i
);
  import ccc_pkg::*;

  logic                   in_xfer;
  cmd_e                   cmd;
  clock_time_t            req_time;
  logic                   set_ok;
  clock_time_t            time_d;
  clock_time_t            time_q;
  status_e                status_d;
  logic [TickMsWidth-1:0] tick_ms_q;
  logic                   winter_time_q;
  logic                   out_valid_d;
  logic                   out_valid_q;
  clock_time_t            out_time_q;
  status_e                out_status_q;

  // Unpack the request.
  always_comb begin
    cmd              = cmd_e'(s_axis_tuser);
    req_time.day     = s_axis_tdata[4:0];
    req_time.month   = s_axis_tdata[8:5];
    req_time.year    = s_axis_tdata[24:9];
    req_time.hour    = s_axis_tdata[29:25];
    req_time.minute  = s_axis_tdata[35:30];
    req_time.second  = s_axis_tdata[41:36];
    req_time.msecond = s_axis_tdata[51:42];
  end

  ccc_set_check u_set_check (
    .set_time_i (req_time),
    .set_ok_o   (set_ok)
  );

  ccc_advance u_advance (
    .time_i        (time_q),
    .cmd_i         (cmd),
    .set_time_i    (req_time),
    .set_ok_i      (set_ok),
    .tick_ms_i     (tick_ms_q),
    .winter_time_i (winter_time_q),
    .time_o        (time_d),
    .status_o      (status_d)
  );

  // Handshake: take a new item whenever the result register can be refilled.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_valid_d   = in_xfer || (out_valid_q && !m_axis_tready);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ms_q     <= TickMsWidth'(TickMsReset);
      winter_time_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        RegTickMs:     tick_ms_q     <= cfg_wdata_i;
        RegWinterTime: winter_time_q <= cfg_wdata_i[0];
        default:       ;
      endcase
    end
  end

  // Held calendar time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '{year: 16'(YearReset), month: 4'd1, day: 5'd1, default: '0};
    end else if (in_xfer) begin
      time_q <= time_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_time_q   <= time_d;
      out_status_q <= status_d;
    end
  end

  // Pack the result.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {4'b0000, out_time_q.msecond, out_time_q.second,
                          out_time_q.minute, out_time_q.hour, out_time_q.year,
                          out_time_q.month, out_time_q.day};

  // The held time always keeps a legal date, hour and millisecond.
  `CCC_ASSERT_IMP(a_time_legal, clk_i, rst_ni, 1'b1,
    (time_q.month >= 4'd1) && (time_q.month <= 4'(MonthsPerYr)) && (time_q.day >= 5'd1)
    && (time_q.day <= month_len(time_q.month, time_q.year))
    && (time_q.hour < 5'(HoursPerDay)) && (time_q.msecond < 10'(MsPerSec)))
  // A rejected set leaves the held time untouched.
  `CCC_ASSERT_NXT(a_reject_keeps, clk_i, rst_ni, in_xfer && (cmd == CmdSet) && !set_ok, $stable(time_q))
  // Every accepted item yields a pending result.
  `CCC_ASSERT_NXT(a_xfer_result, clk_i, rst_ni, in_xfer, out_valid_q)
  // A pending result always shows the time currently held.
  `CCC_ASSERT_IMP(a_result_current, clk_i, rst_ni, out_valid_q, out_time_q == time_q)

endmodule
